// ----- hdl/usoe_pkg.sv -----
package usoe_pkg;

    localparam int SET_CAPACITY = 16;
    localparam int MAX_RESULTS  = 32;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int MODE_W       = 2;

    localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN         = 2'd2;

    localparam logic [MODE_W-1:0] MODE_UNION     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERSECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF      = 2'd2;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic run_start;
        logic swap;
        logic oi_clear;
        logic oi_inc;
        logic ki_clear;
        logic ki_inc;
        logic cand_capture;
        logic push_pend;
        logic pend_load;
        logic push_final;
        logic sets_clear;
    } usoe_cmd_t;

    typedef struct packed {
        logic oi_done;
        logic inner_empty;
        logic scan_done;
        logic match;
        logic out_free;
        logic pend_valid;
        logic res_full;
    } usoe_status_t;

endpackage

// ----- hdl/usoe_in_if.sv -----
interface usoe_in_if import usoe_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] element_value;

    modport source (output valid, output cmd, output element_value, input ready);
    modport sink (input valid, input cmd, input element_value, output ready);
endinterface

// ----- hdl/usoe_out_if.sv -----
interface usoe_out_if import usoe_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic                      is_last;
    logic                      result_empty;
    logic                      load_overflow;

    modport source (
        output valid, output result_value, output is_last,
        output result_empty, output load_overflow, input ready
    );
    modport sink (
        input valid, input result_value, input is_last,
        input result_empty, input load_overflow, output ready
    );
endinterface

// ----- hdl/usoe_ram.sv -----
module usoe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/usoe_datapath.sv -----
module usoe_datapath import usoe_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  usoe_cmd_t                 cmd,
    input  logic signed [VALUE_W-1:0] load_value,
    output usoe_status_t              status,
    usoe_out_if.source                result
);

    logic [CNT_W-1:0]   first_cnt_reg;
    logic [CNT_W-1:0]   second_cnt_reg;
    logic               overflow_reg;
    logic [CNT_W-1:0]   oi_reg;
    logic [CNT_W-1:0]   ki_reg;
    logic [RES_W-1:0]   res_cnt_reg;
    logic               pend_valid_reg;
    logic               out_valid_reg;

    logic [VALUE_W-1:0] cand_reg;
    logic [VALUE_W-1:0] pend_value_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_empty_reg;
    logic               out_ovf_reg;

    logic               first_full;
    logic               second_full;
    logic               first_we;
    logic               second_we;
    logic [CNT_W-1:0]   outer_cnt;
    logic [CNT_W-1:0]   inner_cnt;
    logic [IDX_W-1:0]   first_rd_addr;
    logic [IDX_W-1:0]   second_rd_addr;
    logic [VALUE_W-1:0] first_rd_data;
    logic [VALUE_W-1:0] second_rd_data;
    logic [VALUE_W-1:0] outer_rd_data;
    logic [VALUE_W-1:0] inner_rd_data;
    logic               out_free;

    assign first_full  = (first_cnt_reg == CNT_W'(SET_CAPACITY));
    assign second_full = (second_cnt_reg == CNT_W'(SET_CAPACITY));
    assign first_we    = cmd.load_first && !first_full;
    assign second_we   = cmd.load_second && !second_full;

    // In the second union phase the second set is walked and the first one scanned
    assign outer_cnt      = cmd.swap ? second_cnt_reg : first_cnt_reg;
    assign inner_cnt      = cmd.swap ? first_cnt_reg : second_cnt_reg;
    assign first_rd_addr  = cmd.swap ? ki_reg[IDX_W-1:0] : oi_reg[IDX_W-1:0];
    assign second_rd_addr = cmd.swap ? oi_reg[IDX_W-1:0] : ki_reg[IDX_W-1:0];
    assign outer_rd_data  = cmd.swap ? second_rd_data : first_rd_data;
    assign inner_rd_data  = cmd.swap ? first_rd_data : second_rd_data;

    usoe_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SET_CAPACITY)
    ) u_first_ram (
        .clk     (clk),
        .wr_en   (first_we),
        .wr_addr (first_cnt_reg[IDX_W-1:0]),
        .wr_data (load_value),
        .rd_addr (first_rd_addr),
        .rd_data (first_rd_data)
    );

    usoe_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SET_CAPACITY)
    ) u_second_ram (
        .clk     (clk),
        .wr_en   (second_we),
        .wr_addr (second_cnt_reg[IDX_W-1:0]),
        .wr_data (load_value),
        .rd_addr (second_rd_addr),
        .rd_data (second_rd_data)
    );

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        status.oi_done     = (oi_reg == outer_cnt);
        status.inner_empty = (inner_cnt == '0);
        // ki runs one ahead of the entry whose data is on the read port
        status.scan_done   = (ki_reg == inner_cnt);
        status.match       = (inner_rd_data == cand_reg);
        status.out_free    = out_free;
        status.pend_valid  = pend_valid_reg;
        status.res_full    = (res_cnt_reg == RES_W'(MAX_RESULTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            overflow_reg   <= 1'b0;
            oi_reg         <= '0;
            ki_reg         <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (first_we)
            begin
                first_cnt_reg <= first_cnt_reg + CNT_W'(1);
            end
            if (second_we)
            begin
                second_cnt_reg <= second_cnt_reg + CNT_W'(1);
            end
            if ((cmd.load_first && first_full) || (cmd.load_second && second_full))
            begin
                overflow_reg <= 1'b1;
            end
            if (cmd.sets_clear)
            begin
                first_cnt_reg  <= '0;
                second_cnt_reg <= '0;
                overflow_reg   <= 1'b0;
            end

            if (cmd.oi_clear)
            begin
                oi_reg <= '0;
            end
            else if (cmd.oi_inc)
            begin
                oi_reg <= oi_reg + CNT_W'(1);
            end

            if (cmd.ki_clear)
            begin
                ki_reg <= '0;
            end
            else if (cmd.ki_inc)
            begin
                ki_reg <= ki_reg + CNT_W'(1);
            end

            if (cmd.run_start)
            begin
                res_cnt_reg    <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.pend_load)
            begin
                res_cnt_reg    <= res_cnt_reg + RES_W'(1);
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.push_final)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.push_pend || cmd.push_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cand_capture)
        begin
            cand_reg <= outer_rd_data;
        end
        if (cmd.pend_load)
        begin
            pend_value_reg <= cand_reg;
        end
        if (cmd.push_pend)
        begin
            out_value_reg <= pend_value_reg;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b0;
            out_ovf_reg   <= overflow_reg;
        end
        else if (cmd.push_final)
        begin
            // an empty answer still sends one item, value zero
            out_value_reg <= pend_valid_reg ? pend_value_reg : '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= !pend_valid_reg;
            out_ovf_reg   <= overflow_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_value  = out_value_reg;
    assign result.is_last       = out_last_reg;
    assign result.result_empty  = out_empty_reg;
    assign result.load_overflow = out_ovf_reg;

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_pend || cmd.push_final) |-> out_free)
        else $error("result pushed over an item not yet taken");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sets_clear |=> (first_cnt_reg == '0 && second_cnt_reg == '0 && !overflow_reg))
        else $error("sets not emptied after run");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_cnt_reg <= CNT_W'(SET_CAPACITY)) && (second_cnt_reg <= CNT_W'(SET_CAPACITY)))
        else $error("set count beyond capacity");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && out_value_reg == '0))
        else $error("empty marker without last or with nonzero value");

endmodule

// ----- hdl/usoe_ctrl.sv -----
module usoe_ctrl import usoe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,
    usoe_in_if.sink           item,
    input  usoe_status_t      status,
    output usoe_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_OREAD  = 6'b000010,
        S_OLATCH = 6'b000100,
        S_SCAN   = 6'b001000,
        S_PUSH   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              phase2_reg;
    logic              phase2_next;
    logic [MODE_W-1:0] mode_reg;
    logic              accept;
    logic              want;
    logic              union_first;
    logic              mode_known;

    assign item.ready  = (state_reg == S_IDLE);
    assign accept      = item.valid && item.ready;
    // union's second phase keeps elements not found, like difference
    assign want        = (mode_reg == MODE_INTERSECT);
    assign union_first = (mode_reg == MODE_UNION) && !phase2_reg;
    assign mode_known  = (mode_reg == MODE_UNION) || (mode_reg == MODE_INTERSECT)
                         || (mode_reg == MODE_DIFF);

    always_comb
    begin
        state_next  = state_reg;
        phase2_next = phase2_reg;
        cmd         = '0;
        cmd.swap    = phase2_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.cmd)
                        CMD_LOAD_FIRST:  cmd.load_first = 1'b1;
                        CMD_LOAD_SECOND: cmd.load_second = 1'b1;
                        CMD_RUN:
                        begin
                            cmd.run_start = 1'b1;
                            cmd.oi_clear  = 1'b1;
                            phase2_next   = 1'b0;
                            state_next    = mode_known ? S_OREAD : S_FINISH;
                        end
                        default: ;
                    endcase
                end
            end
            S_OREAD:
            begin
                if (status.oi_done)
                begin
                    if (union_first)
                    begin
                        phase2_next  = 1'b1;
                        cmd.oi_clear = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    cmd.ki_clear = 1'b1;
                    state_next   = S_OLATCH;
                end
            end
            S_OLATCH:
            begin
                cmd.cand_capture = 1'b1;
                cmd.ki_inc       = 1'b1;
                if (union_first)
                begin
                    state_next = S_PUSH;
                end
                else if (status.inner_empty)
                begin
                    if (want)
                    begin
                        cmd.oi_inc = 1'b1;
                        state_next = S_OREAD;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.ki_inc = 1'b1;
                if (status.match || status.scan_done)
                begin
                    // keep when found matches what the mode wants
                    if (status.match == want)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        cmd.oi_inc = 1'b1;
                        state_next = S_OREAD;
                    end
                end
            end
            S_PUSH:
            begin
                if (status.res_full)
                begin
                    state_next = S_FINISH;
                end
                else if (!status.pend_valid || status.out_free)
                begin
                    cmd.push_pend = status.pend_valid;
                    cmd.pend_load = 1'b1;
                    cmd.oi_inc    = 1'b1;
                    state_next    = S_OREAD;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.push_final = 1'b1;
                    cmd.sets_clear = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase2_reg <= 1'b0;
            mode_reg   <= MODE_UNION;
        end
        else
        begin
            state_reg  <= state_next;
            phase2_reg <= phase2_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    a_swap_only_union: assert property (@(posedge clk) disable iff (!rst_n)
        (phase2_reg && state_reg != S_IDLE) |-> (mode_reg == MODE_UNION))
        else $error("second phase entered outside union");

    a_scan_follows_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_OLATCH))
        else $error("scan entered without an outer element");

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_RUN) |=> !item.ready)
        else $error("input taken during run");

endmodule

// ----- hdl/unsorted_set_operation_engine_unit.sv -----
// channel   role       handshake            payload
// item      sink       valid/ready          cmd, element_value
// result    source     valid/ready          result_value, is_last, result_empty,
//                                           load_overflow
// cfg       write-only cfg_wr_en            cfg_wr_data (operation_mode)
//
// A load transaction is taken in S_IDLE. A run fetches each walked element in
// S_OREAD and S_OLATCH, scans the other set in S_SCAN entry by entry (stopping
// at a match), and queues the element in S_PUSH when kept; each phase ends in
// S_OREAD and the run closes in S_FINISH. The first union phase does not scan.
// The scan reads one entry per cycle from the single read port of each set RAM.
// Reset clears counts, valid and overflow flags and control at once; the set RAMs are not cleared.
// A held result stalls the run only when the next kept element or the final item needs the output.
module unsorted_set_operation_engine_unit import usoe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data,
    usoe_in_if.sink           item,
    usoe_out_if.source        result
);

    usoe_cmd_t    cmd;
    usoe_status_t status;

    usoe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .status      (status),
        .cmd         (cmd)
    );

    usoe_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (item.element_value),
        .status     (status),
        .result     (result)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import usoe_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RUN_LATENCY     = SET_CAPACITY * (SET_CAPACITY + 3) * 2 + 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 10;
    localparam int HOLD_CYCLES     = 700;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
        logic                      is_empty;
        logic                      overflow;
    } set_answer_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MODE_W-1:0] cfg_wr_data;

    usoe_in_if  item();
    usoe_out_if result();

    unsorted_set_operation_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .result      (result)
    );

    // predictor state
    logic signed [VALUE_W-1:0] first_set[$];
    logic signed [VALUE_W-1:0] second_set[$];
    logic                      overflow_flag = 1'b0;
    logic [MODE_W-1:0]         active_mode = MODE_UNION;
    set_answer_t               answers_due[$];

    int error_count     = 0;
    int transactions    = 0;
    int runs_done       = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int stall_left      = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit set_holds(input logic signed [VALUE_W-1:0] members[$],
                                     input logic signed [VALUE_W-1:0] v);
        foreach (members[i])
        begin
            if (members[i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void run_set_operation();
        logic signed [VALUE_W-1:0] answer[$];
        set_answer_t entry;
        if (active_mode == MODE_UNION)
        begin
            answer = first_set;
            foreach (second_set[i])
            begin
                if (!set_holds(first_set, second_set[i]))
                    answer.push_back(second_set[i]);
            end
        end
        else if (active_mode == MODE_INTERSECT || active_mode == MODE_DIFF)
        begin
            foreach (first_set[i])
            begin
                if (set_holds(second_set, first_set[i]) == (active_mode == MODE_INTERSECT))
                    answer.push_back(first_set[i]);
            end
        end
        while (answer.size() > MAX_RESULTS)
            void'(answer.pop_back());
        if (answer.size() == 0)
        begin
            entry = '{value: '0, is_last: 1'b1, is_empty: 1'b1, overflow: overflow_flag};
            answers_due.push_back(entry);
        end
        else
        begin
            foreach (answer[i])
            begin
                entry.value    = answer[i];
                entry.is_last  = (i == answer.size() - 1);
                entry.is_empty = 1'b0;
                entry.overflow = overflow_flag;
                answers_due.push_back(entry);
            end
        end
        first_set.delete();
        second_set.delete();
        overflow_flag = 1'b0;
        runs_done++;
    endfunction

    function automatic void model_transaction(input logic [CMD_W-1:0] c,
                                              input logic signed [VALUE_W-1:0] v);
        case (c)
            CMD_LOAD_FIRST:
            begin
                if (first_set.size() < SET_CAPACITY)
                    first_set.push_back(v);
                else
                    overflow_flag = 1'b1;
            end
            CMD_LOAD_SECOND:
            begin
                if (second_set.size() < SET_CAPACITY)
                    second_set.push_back(v);
                else
                    overflow_flag = 1'b1;
            end
            CMD_RUN:
                run_set_operation();
            default:
                ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // hold valid across back-to-back transactions; lower it only while idling
    task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid         <= 1'b1;
        item.cmd           <= c;
        item.element_value <= v;
        do
            @(posedge clk);
        while (!item.ready);
        transactions++;
        model_transaction(c, v);
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (RUN_LATENCY) @(posedge clk);
    endtask

    task automatic set_operation_mode(input logic [MODE_W-1:0] m);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        active_mode = m;
    endtask

    task automatic set_idling(input int sender_pct, input int sink_pct);
        sender_idle_pct = sender_pct;
        sink_stall_pct  = sink_pct;
    endtask

    task automatic test_empty_run();
        set_operation_mode(MODE_UNION);
        send_item(CMD_RUN, 32'sd0);
    endtask

    task automatic test_union();
        send_item(CMD_LOAD_FIRST, 32'sh8000_0000);
        send_item(CMD_LOAD_FIRST, 32'sh7fff_ffff);
        send_item(CMD_UNUSED, 32'sh5a5a_5a5a);
        send_item(CMD_LOAD_SECOND, 32'sh7fff_ffff);
        send_item(CMD_LOAD_SECOND, -32'sd1);
        send_item(CMD_RUN, -32'sd1);
    endtask

    task automatic test_intersection();
        set_operation_mode(MODE_INTERSECT);
        send_item(CMD_LOAD_FIRST, 32'sd5);
        send_item(CMD_LOAD_FIRST, -32'sd1);
        send_item(CMD_LOAD_FIRST, 32'sd5);
        send_item(CMD_LOAD_SECOND, 32'sd5);
        send_item(CMD_RUN, 32'sd0);
    endtask

    task automatic test_difference();
        set_operation_mode(MODE_DIFF);
        send_item(CMD_LOAD_FIRST, 32'sd7);
        send_item(CMD_LOAD_FIRST, 32'sd8);
        send_item(CMD_LOAD_SECOND, 32'sd8);
        send_item(CMD_RUN, 32'sd0);
    endtask

    task automatic test_unused_mode();
        set_operation_mode(MODE_UNUSED);
        send_item(CMD_LOAD_FIRST, 32'sd1);
        send_item(CMD_RUN, 32'sd0);
    endtask

    // overfill the first set and hold the output so the run backs up into the input
    task automatic test_held_output_overflow();
        logic signed [VALUE_W-1:0] loaded[SET_CAPACITY + 1];
        int k;
        set_operation_mode(MODE_UNION);
        set_idling(0, 0);
        stall_left <= HOLD_CYCLES;
        for (k = 0; k <= SET_CAPACITY; k++)
        begin
            loaded[k] = $urandom;
            send_item(CMD_LOAD_FIRST, loaded[k]);
        end
        send_item(CMD_LOAD_SECOND, loaded[0]);
        send_item(CMD_LOAD_SECOND, loaded[SET_CAPACITY]);
        send_item(CMD_LOAD_SECOND, $urandom);
        send_item(CMD_LOAD_SECOND, loaded[3]);
        send_item(CMD_RUN, 32'sd0);
        // keep offering while the block is stuck behind the held result
        for (k = 0; k < 4; k++)
            send_item(k[0] ? CMD_LOAD_SECOND : CMD_LOAD_FIRST, loaded[k]);
        send_item(CMD_RUN, 32'sd0);
    endtask

    task automatic send_random_sequence(inout int counted);
        logic signed [VALUE_W-1:0] pool[6];
        logic signed [VALUE_W-1:0] v;
        int n_first;
        int n_second;
        foreach (pool[i])
            pool[i] = $urandom;
        n_first  = ($urandom_range(9) == 0) ? $urandom_range(SET_CAPACITY + 3)
                                            : $urandom_range(8);
        n_second = ($urandom_range(9) == 0) ? $urandom_range(SET_CAPACITY + 3)
                                            : $urandom_range(8);
        while (n_first + n_second != 0)
        begin
            if ($urandom_range(11) == 0)
                send_item(CMD_UNUSED, $urandom);
            v = ($urandom_range(3) == 0) ? $urandom : pool[$urandom_range(5)];
            if (n_second == 0 || (n_first != 0 && $urandom_range(1) == 0))
            begin
                send_item(CMD_LOAD_FIRST, v);
                n_first--;
            end
            else
            begin
                send_item(CMD_LOAD_SECOND, v);
                n_second--;
            end
            counted++;
        end
        // drop the run now and then so loads pile into the next sequence
        if ($urandom_range(7) != 0)
        begin
            send_item(CMD_RUN, $urandom);
            counted++;
        end
    endtask

    task automatic test_random_sets();
        int sender_pct[4] = '{0, 64, 0, 22};
        int sink_pct[4]   = '{0, 0, 64, 22};
        int counted;
        int target;
        counted = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_results();
            set_idling(sender_pct[phase], sink_pct[phase]);
            target = counted + ITEMS_PER_PHASE;
            while (counted < target)
            begin
                if ($urandom_range(1) == 0)
                    set_operation_mode(($urandom_range(9) == 0) ? MODE_UNUSED
                                                                : MODE_W'($urandom_range(2)));
                send_random_sequence(counted);
            end
        end
        set_idling(0, 0);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        result.ready <= (stall_left == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        set_answer_t due;
        if (rst_n && result.valid && result.ready)
        begin
            if (answers_due.size() == 0)
                report_mismatch($sformatf("result %0d with nothing pending",
                                          result.result_value));
            else
            begin
                due = answers_due.pop_front();
                results_checked++;
                if (result.result_value !== due.value)
                    report_mismatch($sformatf("result_value %0d, predicted %0d",
                                              result.result_value, due.value));
                if (result.is_last !== due.is_last)
                    report_mismatch($sformatf("is_last %b, predicted %b",
                                              result.is_last, due.is_last));
                if (result.result_empty !== due.is_empty)
                    report_mismatch($sformatf("result_empty %b, predicted %b",
                                              result.result_empty, due.is_empty));
                if (result.load_overflow !== due.overflow)
                    report_mismatch($sformatf("load_overflow %b, predicted %b",
                                              result.load_overflow, due.overflow));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: timeout after %0d cycles, %0d results pending",
                 cycle_count, answers_due.size());
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = MODE_UNION;
        item.valid         = 1'b0;
        item.cmd           = CMD_LOAD_FIRST;
        item.element_value = '0;
        result.ready       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_run();
        test_union();
        test_intersection();
        test_difference();
        test_unused_mode();
        test_held_output_overflow();
        test_random_sets();
        drain_results();

        for (int k = 0; answers_due.size() != 0 && k < 4; k++)
            @(posedge clk);
        if (answers_due.size() != 0)
            report_mismatch($sformatf("%0d predicted results never came",
                                      answers_due.size()));
        $display("tb_top: %0d transactions, %0d runs, %0d results checked",
                 transactions, runs_done, results_checked);
        $display("tb_top: all modes, overfilled sets, held output and idle mixes covered");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/usoe_pkg.sv
hdl/usoe_in_if.sv
hdl/usoe_out_if.sv
hdl/usoe_ram.sv
hdl/usoe_datapath.sv
hdl/usoe_ctrl.sv
hdl/unsorted_set_operation_engine_unit.sv
tb/tb_top.sv
